// File: src/bsee_pkg.sv
package bsee_pkg;

    localparam int          MAX_OUTPUT_WORDS_DEF = 64;
    localparam int          CFG_W                = 10;
    localparam logic [9:0]  OUT_BYTES_RESET      = 10'd32;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_MUL,
        ST_SQUEEZE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  valid_bytes;
        logic        last_word;
    } t_out;

endpackage

// File: src/byte_stream_entropy_extractor.sv
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+-------------------------------
// in       | i_in_valid   | o_in_ready   | i_in_data  (t_in)
// out      | o_out_valid  | i_out_ready  | o_out_data (t_out)
// cfg      | i_cfg_valid  | o_cfg_ready  | i_cfg_data (output_bytes)
//
// An input byte passes from accept to the next accept through the accept
// itself, one xor and gamma add, then two 64-bit multiplies, each on the one
// shared 32x32 multiplier (three partial products, registered).
// On a last byte, each output word is generated in the squeeze state, then is held
// in the output register until taken; input stays not ready meanwhile.
// Synchronous active-low reset clears state, position and sets length to 32.
module byte_stream_entropy_extractor
    import bsee_pkg::*;
#(
    parameter int MAX_OUTPUT_WORDS = MAX_OUTPUT_WORDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam logic [CFG_W-1:0] MAX_BYTES = CFG_W'(8 * MAX_OUTPUT_WORDS);

    t_state             r_state, n_state;
    logic [63:0]        r_mix [4];
    logic [2:0]         r_pos;
    logic [CFG_W-1:0]   r_output_bytes;
    logic [CFG_W-1:0]   r_left;
    logic [7:0]         r_byte;
    logic               r_last;
    logic [1:0]         r_step;
    logic               r_pass;
    logic [63:0]        r_z;
    logic [63:0]        r_acc;
    logic [63:0]        r_prod;
    t_out               r_out;

    logic [1:0]         w_idx;
    logic [1:0]         w_nxt;
    logic [63:0]        w_absorb;
    logic [63:0]        w_const;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_prod;
    logic [63:0]        w_sum;
    logic [63:0]        w_xa;
    logic [63:0]        w_xs1;
    logic [CFG_W-1:0]   w_total;
    logic               w_out_fire;

    assign w_idx    = r_pos[1:0];
    assign w_nxt    = w_idx + 2'd1;
    assign w_absorb = (r_mix[w_idx] ^ (64'(r_byte) << {r_pos, 3'b000})) + GOLDEN_GAMMA;

    // shared multiplier: lo*lo, hi*lo, lo*hi; only the low 64 bits matter
    assign w_const = r_pass ? MIX_MUL_B : MIX_MUL_A;
    assign w_mul_a = (r_step == 2'd1) ? r_z[63:32] : r_z[31:0];
    assign w_mul_b = (r_step == 2'd2) ? w_const[63:32] : w_const[31:0];
    assign w_prod  = 64'(w_mul_a) * 64'(w_mul_b);
    assign w_sum   = r_acc + {r_prod[31:0], 32'b0};

    // xorshift128+ step on words 0 and 1
    assign w_xa  = r_mix[0] ^ (r_mix[0] << 23);
    assign w_xs1 = w_xa ^ r_mix[1] ^ (w_xa >> 17) ^ (r_mix[1] >> 26);

    assign w_total = (r_output_bytes == '0)       ? CFG_W'(1)  :
                     (r_output_bytes > MAX_BYTES) ? MAX_BYTES  : r_output_bytes;

    assign w_out_fire = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_ABSORB;
            end
            ST_ABSORB: n_state = ST_MUL;
            ST_MUL: begin
                if (r_step == 2'd3 && r_pass) n_state = r_last ? ST_SQUEEZE : ST_IDLE;
            end
            ST_SQUEEZE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) n_state = r_out.last_word ? ST_IDLE : ST_SQUEEZE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
        o_out_data  = r_out;
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_pos          <= '0;
            r_step         <= '0;
            r_pass         <= 1'b0;
            r_output_bytes <= OUT_BYTES_RESET;
            for (int k = 0; k < 4; k++) r_mix[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_output_bytes <= i_cfg_data;

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_byte <= i_in_data.data_byte;
                        r_last <= i_in_data.last_byte;
                    end
                end
                ST_ABSORB: begin
                    r_mix[w_idx] <= w_absorb;
                    r_z          <= w_absorb ^ (w_absorb >> 30);
                    r_step       <= '0;
                    r_pass       <= 1'b0;
                end
                ST_MUL: begin
                    r_prod <= w_prod;
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd1) r_acc <= r_prod;
                    if (r_step == 2'd2) r_acc <= w_sum;
                    if (r_step == 2'd3) begin
                        r_pass <= ~r_pass;
                        if (!r_pass) begin
                            r_z <= w_sum ^ (w_sum >> 27);
                        end else begin
                            r_mix[w_nxt] <= w_sum ^ (w_sum >> 31);
                            r_pos        <= r_pos + 3'd1;
                            r_left       <= w_total;
                        end
                    end
                end
                ST_SQUEEZE: begin
                    r_mix[0]          <= r_mix[1];
                    r_mix[1]          <= w_xs1;
                    r_out.out_word    <= w_xs1 + r_mix[1];
                    r_out.valid_bytes <= (r_left < CFG_W'(8)) ? r_left[3:0] : 4'd8;
                    r_out.last_word   <= (r_left <= CFG_W'(8));
                    r_left            <= r_left - CFG_W'(8);
                end
                ST_OUT: begin
                    if (i_out_ready && r_out.last_word) begin
                        for (int k = 0; k < 4; k++) r_mix[k] <= '0;
                        r_pos <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // one side at a time: never taking a byte while a word is offered
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output word pending");

    // a finished squeeze leaves a cleared position and a ready input
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_fire && o_out_data.last_word |=> o_in_ready && r_pos == '0)
        else $error("state not cleared after final word");

    // only the final word may be partial, and never empty
    a_vbytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_word ? (o_out_data.valid_bytes != 4'd0 &&
                         o_out_data.valid_bytes <= 4'd8) : o_out_data.valid_bytes == 4'd8))
        else $error("bad valid byte count");

    // an accepted byte keeps input ready low through absorb and into the first multiply step
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready)
        else $error("ready too early after byte accept");

endmodule

// File: dv/byte_stream_entropy_extractor_test.sv
`timescale 1ns / 1ps

module byte_stream_entropy_extractor_test;
    import bsee_pkg::*;

    localparam int     LEN_CAP       = 8 * MAX_OUTPUT_WORDS_DEF;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     RANDOM_ITEMS  = 380;
    localparam longint CYCLE_LIMIT   = 6_000_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    t_in              in_data   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;
    wire              in_ready;
    wire              out_valid;
    wire              cfg_ready;
    t_out             out_data;

    // predictor state
    logic [63:0]      pool_w [4] = '{default: '0};
    logic [2:0]       lane_pos   = '0;
    logic [CFG_W-1:0] out_len    = OUT_BYTES_RESET;

    t_in    msg_bytes_q [$];
    t_out   squeeze_q [$];
    int     bytes_pending = 0;
    int     items_sent    = 0;
    int     err_cnt       = 0;
    int     gap_left      = 0;
    int     stall_left    = 0;
    longint cycles        = 0;
    bit     calm          = 1'b0;

    byte_stream_entropy_extractor dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [63:0] splitmix_mix(input logic [63:0] z);
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    // absorb one byte; on the last byte of a message, queue the squeezed words
    task automatic absorb_byte(input t_in b);
        logic [1:0]  w;
        logic [1:0]  nx;
        logic [63:0] a;
        logic [63:0] c;
        int          total;
        int          words;
        int          left;
        t_out        r;
        w  = lane_pos[1:0];
        nx = w + 2'd1;
        pool_w[w] = pool_w[w] ^ (64'(b.data_byte) << (8 * lane_pos));
        pool_w[w] = pool_w[w] + GOLDEN_GAMMA;
        pool_w[nx] = splitmix_mix(pool_w[w]);
        lane_pos = lane_pos + 3'd1;
        if (!b.last_byte)
            return;
        total = int'(out_len);
        if (total == 0)
            total = 1;
        if (total > LEN_CAP)
            total = LEN_CAP;
        words = (total + 7) / 8;
        for (int k = 0; k < words; k++) begin
            left = total - 8 * k;
            a = pool_w[0];
            c = pool_w[1];
            pool_w[0] = c;
            a = a ^ (a << 23);
            pool_w[1] = a ^ c ^ (a >> 17) ^ (c >> 26);
            r.out_word    = pool_w[1] + c;
            r.valid_bytes = (left < 8) ? 4'(left) : 4'd8;
            r.last_word   = (k == words - 1);
            squeeze_q.push_back(r);
        end
        pool_w   = '{default: '0};
        lane_pos = '0;
    endtask

    // mostly zero, some short, a few long; none while calm
    function automatic int gap_len(input int short_pct, input int long_pct);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r >= short_pct + long_pct)
            return 0;
        if (r < short_pct)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    always @(posedge clk) begin : drive_bytes
        logic nxt_valid;
        t_in  nxt_data;
        nxt_valid = in_valid;
        nxt_data  = in_data;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                absorb_byte(in_data);
                bytes_pending--;
                nxt_valid = 1'b0;
                gap_left  = gap_len(35, 8);
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (msg_bytes_q.size() > 0) begin
                    nxt_valid = 1'b1;
                    nxt_data  = msg_bytes_q.pop_front();
                end
            end
        end
        in_valid <= nxt_valid;
        in_data  <= nxt_data;
    end

    always @(posedge clk) begin : take_words
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (squeeze_q.size() == 0) begin
                $error("unexpected output word %h", out_data.out_word);
                err_cnt++;
            end else begin
                want = squeeze_q.pop_front();
                if (out_data.out_word !== want.out_word) begin
                    $error("out_word: expected %h, got %h", want.out_word, out_data.out_word);
                    err_cnt++;
                end
                if (out_data.valid_bytes !== want.valid_bytes) begin
                    $error("valid_bytes: expected %0d, got %0d",
                           want.valid_bytes, out_data.valid_bytes);
                    err_cnt++;
                end
                if (out_data.last_word !== want.last_word) begin
                    $error("last_word: expected %0d, got %0d",
                           want.last_word, out_data.last_word);
                    err_cnt++;
                end
            end
        end
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready  <= 1'b1;
            stall_left = gap_len(25, 3);
        end
    end

    task automatic push_byte(input logic [7:0] d, input logic last);
        t_in b;
        b.data_byte = d;
        b.last_byte = last;
        msg_bytes_q.push_back(b);
        bytes_pending++;
        items_sent++;
    endtask

    task automatic send_msg(input int len);
        for (int i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    function automatic int msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 8);
        if (r < 90)
            return $urandom_range(9, 20);
        return $urandom_range(21, 48);
    endfunction

    function automatic logic [CFG_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return CFG_W'($urandom_range(1, 64));
        if (r < 75)
            return CFG_W'($urandom_range(65, 200));
        if (r < 85) begin
            case ($urandom_range(0, 4))
                0:       return '0;
                1:       return CFG_W'(1);
                2:       return CFG_W'(8);
                3:       return CFG_W'(LEN_CAP);
                default: return '1;
            endcase
        end
        return CFG_W'($urandom_range(201, 1023));
    endfunction

    // wait until every byte is taken and every word has come back
    task automatic settle();
        while (bytes_pending != 0 || squeeze_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // called once settle() has returned, only while the block is idle
    task automatic write_out_len(input logic [CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        out_len = v;
    endtask

    initial begin : stimulus
        logic [CFG_W-1:0] corner_len [7];
        int               base_items;
        corner_len = '{CFG_W'(0), CFG_W'(1), CFG_W'(7), CFG_W'(8), CFG_W'(9),
                       CFG_W'(LEN_CAP), '1};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length: one-byte messages, then a message that wraps the lanes
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        for (int i = 0; i < 8; i++)
            push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);

        // zero length, partial words, one full word, max and above max
        foreach (corner_len[i]) begin
            settle();
            write_out_len(corner_len[i]);
            push_byte(8'($urandom_range(0, 255)), 1'b1);
        end

        base_items = items_sent;
        while (items_sent - base_items < RANDOM_ITEMS) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            write_out_len(pick_len());
            repeat ($urandom_range(3, 8))
                send_msg(msg_len());
        end

        settle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
